// ----- hdl/blg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

   localparam int COORD_BITS    = 11;
   localparam int ERR_BITS      = COORD_BITS + 3;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef struct packed {
      logic      is_start;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      coord_type delta_x;
      coord_type delta_y;
      logic      steep;
      logic      x_negative;
      logic      y_negative;
      err_type   error_init;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hdl/blg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blg_front
   import blg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire logic      in_mode,
   input  wire coord_type in_x_start,
   input  wire coord_type in_y_start,
   input  wire coord_type in_x_end,
   input  wire coord_type in_y_end,
   output logic           cmd_valid,
   input  wire logic      cmd_ready,
   output cmd_type        cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    x_neg, y_neg, steep;
   coord_type dx, dy, major, minor;

   always_comb begin
      x_neg = in_x_start > in_x_end;
      y_neg = in_y_start > in_y_end;
      dx    = x_neg ? in_x_start - in_x_end : in_x_end - in_x_start;
      dy    = y_neg ? in_y_start - in_y_end : in_y_end - in_y_start;
      steep = !(dy < dx);
      major = steep ? dy : dx;
      minor = steep ? dx : dy;

      cmd_in.is_start   = (in_mode == MODE_START);
      cmd_in.x_start    = in_x_start;
      cmd_in.y_start    = in_y_start;
      cmd_in.x_end      = in_x_end;
      cmd_in.y_end      = in_y_end;
      cmd_in.delta_x    = dx;
      cmd_in.delta_y    = dy;
      cmd_in.steep      = steep;
      cmd_in.x_negative = x_neg;
      cmd_in.y_negative = y_neg;
      cmd_in.error_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
   end

   assign in_ready  = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/blg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blg_queue
   import blg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_cmd,
   output logic         out_valid,
   input  wire logic    out_ready,
   output cmd_type      out_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/blg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blg_back
   import blg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd,
   output logic         out_valid,
   input  wire logic    out_ready,
   output coord_type    out_x,
   output coord_type    out_y,
   output logic         out_last
);

   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   coord_type delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   err_type   error_ff, error_in;
   logic      steep_ff, steep_in, x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic      active_ff, active_in;
   logic      valid_ff, valid_in;
   coord_type pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic      last_ff, last_in;
   logic      pop, emit, last;
   coord_type major, minor, next_x, next_y;
   err_type   twice_major, twice_minor;

   assign cmd_ready = !valid_ff || out_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign emit      = pop && !cmd.is_start && active_ff;
   assign out_valid = valid_ff;
   assign out_x     = pix_x_ff;
   assign out_y     = pix_y_ff;
   assign out_last  = last_ff;

   always_comb begin
      last        = steep_ff ? (cur_y_ff == stop_y_ff) : (cur_x_ff == stop_x_ff);
      major       = steep_ff ? delta_y_ff : delta_x_ff;
      minor       = steep_ff ? delta_x_ff : delta_y_ff;
      twice_major = $signed({2'b00, major, 1'b0});
      twice_minor = $signed({2'b00, minor, 1'b0});
      next_x      = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      next_y      = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      stop_x_in  = stop_x_ff;
      stop_y_in  = stop_y_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      error_in   = error_ff;
      steep_in   = steep_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      active_in  = active_ff;

      if (pop && cmd.is_start) begin
         cur_x_in   = cmd.x_start;
         cur_y_in   = cmd.y_start;
         stop_x_in  = cmd.x_end;
         stop_y_in  = cmd.y_end;
         delta_x_in = cmd.delta_x;
         delta_y_in = cmd.delta_y;
         error_in   = cmd.error_init;
         steep_in   = cmd.steep;
         x_neg_in   = cmd.x_negative;
         y_neg_in   = cmd.y_negative;
         active_in  = 1'b1;
      end else if (emit) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            if (steep_ff) begin
               cur_y_in = next_y;
            end else begin
               cur_x_in = next_x;
            end
            if (!error_ff[ERR_BITS-1]) begin
               if (steep_ff) begin
                  cur_x_in = next_x;
               end else begin
                  cur_y_in = next_y;
               end
               error_in = error_ff - twice_major + twice_minor;
            end else begin
               error_in = error_ff + twice_minor;
            end
         end
      end

      valid_in = valid_ff;
      pix_x_in = pix_x_ff;
      pix_y_in = pix_y_ff;
      last_in  = last_ff;
      if (cmd_ready) begin
         valid_in = emit;
         pix_x_in = cur_x_ff;
         pix_y_in = cur_y_ff;
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      stop_x_ff  <= stop_x_in;
      stop_y_ff  <= stop_y_in;
      delta_x_ff <= delta_x_in;
      delta_y_ff <= delta_y_in;
      error_ff   <= error_in;
      steep_ff   <= steep_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      pix_x_ff   <= pix_x_in;
      pix_y_ff   <= pix_y_in;
      last_ff    <= last_in;
   end

endmodule

`default_nettype wire

// ----- hdl/bresenham_line_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word contents
// req       in         tuser: mode; tdata: x_start, y_start, x_end, y_end
// rsp       out        tdata: pixel_x, pixel_y; tlast: last_pixel
//
// One word is accepted per cycle while req_tready is high; each step word's pixel
// passes through the decode register, the two-entry command queue and the output
// register.
// Synchronous reset clears the handshakes, the queue and the line-active flag.
// A stalled rsp side fills the queue before req_tready drops.

module bresenham_line_generator
   import blg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: x_start, y_start, x_end, y_end.
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // Fields from bit 0: mode.
   input  wire logic [0:0]               req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // Fields from bit 0: pixel_x, pixel_y.
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   logic      front_valid, q_ready, q_valid, q_pop_ready;
   cmd_type   front_cmd, q_cmd;
   coord_type pix_x, pix_y;

   blg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_mode    (req_tuser[0]),
      .in_x_start (req_tdata[COORD_BITS-1:0]),
      .in_y_start (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_x_end   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .in_y_end   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .cmd_valid  (front_valid),
      .cmd_ready  (q_ready),
      .cmd        (front_cmd)
   );

   blg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (q_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_ready (q_pop_ready),
      .out_cmd   (q_cmd)
   );

   blg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_pop_ready),
      .cmd       (q_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (pix_x),
      .out_y     (pix_y),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - 2 * COORD_BITS){1'b0}}, pix_y, pix_x};

   // A start command consumed while the output drains leaves no pixel behind.
   a_start_no_pixel: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_pop_ready && q_cmd.is_start && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("start command produced a pixel");

   // The decode register holds its command while the queue is full.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      front_valid && !q_ready |=> front_valid && $stable(front_cmd))
      else $error("decoded command lost while queue full");

   // The back end takes no command while a pixel waits unaccepted.
   a_back_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !q_pop_ready)
      else $error("command consumed while output stalled");

   // No word leaves in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !q_valid)
      else $error("output or queue valid after reset");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import blg_pkg::*;

   localparam coord_type COORD_MAX      = '1;
   localparam int        ITEM_TARGET    = 1450;
   localparam int        WATCHDOG_LIMIT = 4000;
   localparam int        HOLD_CYCLES    = 300;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // Fields from bit 0: x_start, y_start, x_end, y_end.
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // Fields from bit 0: mode.
   logic [0:0]               req_tuser = MODE_START;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // Fields from bit 0: pixel_x, pixel_y.
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   bresenham_line_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Line state as the block should hold it.
   coord_type ln_x = '0, ln_y = '0, ln_stop_x = '0, ln_stop_y = '0;
   coord_type ln_dx = '0, ln_dy = '0;
   err_type   ln_err = '0;
   logic      ln_steep = 1'b0, ln_x_neg = 1'b0, ln_y_neg = 1'b0, ln_active = 1'b0;

   pixel_type pending_pixels[$];

   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_request  = 0;
   int error_count   = 0;
   int words_sent    = 0;
   int starts_sent   = 0;
   int pixels_seen   = 0;
   int lines_done    = 0;
   int quiet_cycles  = 0;

   function automatic err_type twice(input coord_type v);
      return err_type'({v, 1'b0});
   endfunction

   function automatic coord_type step_toward(input coord_type v, input logic neg);
      return neg ? coord_type'(v - 1'b1) : coord_type'(v + 1'b1);
   endfunction

   // Most gaps are short; a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_type near(input coord_type v, input int reach);
      int t;
      t = int'(v) + int'($urandom_range(0, 2 * reach)) - reach;
      if (t < 0) t = 0;
      if (t > int'(COORD_MAX)) t = int'(COORD_MAX);
      return coord_type'(t);
   endfunction

   function automatic void advance_line(input logic mode, input coord_type xs, ys, xe, ye);
      pixel_type px;
      if (mode == MODE_START) begin
         ln_x_neg  = xs > xe;
         ln_y_neg  = ys > ye;
         ln_dx     = ln_x_neg ? coord_type'(xs - xe) : coord_type'(xe - xs);
         ln_dy     = ln_y_neg ? coord_type'(ys - ye) : coord_type'(ye - ys);
         ln_steep  = !(ln_dy < ln_dx);
         ln_err    = ln_steep ? twice(ln_dx) - err_type'(ln_dy) : twice(ln_dy) - err_type'(ln_dx);
         ln_x      = xs;
         ln_y      = ys;
         ln_stop_x = xe;
         ln_stop_y = ye;
         ln_active = 1'b1;
      end else if (ln_active) begin
         px.x    = ln_x;
         px.y    = ln_y;
         px.last = ln_steep ? (ln_y == ln_stop_y) : (ln_x == ln_stop_x);
         pending_pixels.insert(pending_pixels.size(), px);
         if (px.last) begin
            ln_active = 1'b0;
         end else if (ln_steep) begin
            ln_y = step_toward(ln_y, ln_y_neg);
            if (ln_err >= 0) begin
               ln_err = ln_err - twice(ln_dy);
               ln_x   = step_toward(ln_x, ln_x_neg);
            end
            ln_err = ln_err + twice(ln_dx);
         end else begin
            ln_x = step_toward(ln_x, ln_x_neg);
            if (ln_err >= 0) begin
               ln_err = ln_err - twice(ln_dx);
               ln_y   = step_toward(ln_y, ln_y_neg);
            end
            ln_err = ln_err + twice(ln_dy);
         end
      end
   endfunction

   // Called at a falling edge and returns at a falling edge with tvalid still high.
   task automatic send_word(input logic mode, input coord_type xs, ys, xe, ye);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_BITS'({ye, xe, ys, xs});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
      if (mode == MODE_START) starts_sent++;
      advance_line(mode, xs, ys, xe, ye);
   endtask

   task automatic step_pixel();
      send_word(MODE_STEP, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom));
   endtask

   task automatic finish_line();
      while (ln_active) step_pixel();
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic test_directed_cases();
      // A step word with no line in progress yields nothing.
      step_pixel();
      // Single points at both corners, then a step word once the line is over.
      send_word(MODE_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      step_pixel();
      step_pixel();
      send_word(MODE_START, '0, '0, '0, '0);
      step_pixel();
      // A steep tie walking toward smaller x at the edge of the range.
      send_word(MODE_START, COORD_MAX, '0, coord_type'(COORD_MAX - 2), 11'd2);
      finish_line();
      // A shallow line walking toward smaller y.
      send_word(MODE_START, '0, COORD_MAX, 11'd4, coord_type'(COORD_MAX - 1));
      finish_line();
      // A new start abandons the line in progress.
      send_word(MODE_START, 11'd5, 11'd5, 11'd9, 11'd12);
      step_pixel();
      step_pixel();
      send_word(MODE_START, 11'd20, 11'd30, 11'd17, 11'd26);
      finish_line();
   endtask

   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      hold_request = HOLD_CYCLES;
      send_word(MODE_START, 11'd100, 11'd200, 11'd140, 11'd185);
      finish_line();
      req_gaps_on  = 1'b1;
   endtask

   task automatic test_drain_pause();
      coord_type xs, ys;
      repeat (4) begin
         xs = coord_type'($urandom);
         ys = coord_type'($urandom);
         send_word(MODE_START, xs, ys, near(xs, 6), near(ys, 6));
         finish_line();
         wait_for_drain();
      end
   endtask

   task automatic test_random_lines(input int total);
      coord_type xs, ys, xe, ye;
      int kind, reach, steps;
      bit calm;
      while (words_sent < total) begin
         calm          = ($urandom_range(0, 7) == 0);
         req_gaps_on   = !calm;
         rsp_stalls_on = !calm;
         kind  = $urandom_range(0, 99);
         reach = ($urandom_range(0, 24) == 0) ? 300 : 12;
         xs    = coord_type'($urandom);
         ys    = coord_type'($urandom);
         xe    = near(xs, reach);
         ye    = near(ys, reach);
         if (kind < 78) begin
            send_word(MODE_START, xs, ys, xe, ye);
            finish_line();
            if ($urandom_range(0, 5) == 0) step_pixel();
         end else if (kind < 90) begin
            send_word(MODE_START, xs, ys, xe, ye);
            steps = $urandom_range(0, 4);
            repeat (steps) step_pixel();
         end else if (kind < 96) begin
            send_word(MODE_START, xs, ys, coord_type'($urandom), coord_type'($urandom));
            steps = $urandom_range(0, 6);
            repeat (steps) step_pixel();
         end else begin
            step_pixel();
         end
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Receiver side: random stalls, plus the long hold-off when one is requested.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x    = rsp_tdata[COORD_BITS-1:0];
         got.y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
         got.last = rsp_tlast;
         pixels_seen++;
         if (got.last) lines_done++;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                     $time, got.x, got.y, got.last);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
               $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        $time, want.x, want.y, want.last, got.x, got.y, got.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d pixels still expected",
                     $time, quiet_cycles, pending_pixels.size());
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_backpressure();
      test_drain_pause();
      test_random_lines(ITEM_TARGET);
      wait_for_drain();
      repeat (8) @(negedge clock);
      $display("summary: %0d words sent, %0d of them line starts, in all octants",
               words_sent, starts_sent);
      $display("summary: %0d pixels checked, %0d lines run to their last pixel",
               pixels_seen, lines_done);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- bresenham_line_generator.f -----
hdl/blg_pkg.sv
hdl/blg_front.sv
hdl/blg_queue.sv
hdl/blg_back.sv
hdl/bresenham_line_generator.sv
test/tb_top.sv
